FILE: hdl/rcnp_pkg.sv
package rcnp_pkg;

  // Default bound on the stream position that is reported.
  localparam int MaxObjectsDef = 256;

  // Depth of the queue between the front and back parts.
  localparam int QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX    = 3'd3;
  localparam logic [2:0] RegDirY    = 3'd4;
  localparam logic [2:0] RegDirZ    = 3'd5;
  localparam logic [2:0] RegScale   = 3'd6;

  // Ray and scale registers as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [9:0]         scale;
  } rcnp_cfg_t;

  // One cylinder after the front part has prepared it.
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic signed [47:0] ymin;
    logic signed [47:0] ymax;
    logic [23:0]        radius;
    logic               last;
  } rcnp_item_t;

  // Sequencer states of the back part.
  typedef enum logic [4:0] {
    B_IDLE, B_AXX, B_AZZ, B_R, B_H1, B_H2, B_K1, B_K2, B_RR, B_ARR, B_KK,
    B_SQRT, B_ROOT, B_DIV, B_RNG, B_HY, B_CHECK, B_FIN
  } rcnp_state_t;

  // Magnitude of a signed 64-bit value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m;
  endfunction

endpackage

FILE: hdl/rcnp_mul.sv
module rcnp_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  op_a,
  input  logic [63:0]  op_b,
  input  logic         neg,
  output logic         done,
  output logic [127:0] prod
);
  import rcnp_pkg::*;

  logic [127:0] acc;
  logic [127:0] mcand;
  logic [63:0]  mplier;
  logic         neg_r;
  logic         run;

  // Shift-add multiplier, one multiplier bit a cycle, stops when no ones remain.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && mplier == 64'd0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= 128'd0;
      mcand  <= {64'd0, op_a};
      mplier <= op_b;
      neg_r  <= neg;
    end else if (run) begin
      if (mplier == 64'd0) begin
        prod <= neg_r ? 128'(-acc) : acc;
      end else begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[126:0], 1'b0};
        mplier <= {1'b0, mplier[63:1]};
      end
    end
  end

endmodule

FILE: hdl/rcnp_front.sv
module rcnp_front (
  input  logic                clk,
  input  logic                rst,
  input  rcnp_pkg::rcnp_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [143:0]        in_data,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_pop,
  output rcnp_pkg::rcnp_item_t q_item
);
  import rcnp_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  rcnp_item_t      qmem [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;
  rcnp_item_t      prep;
  logic signed [47:0] by48;
  logic            push;

  // Offsets to the cylinder axis and the height window in Q.14.
  always_comb begin
    by48        = {{16{in_data[63]}}, in_data[63:32]};
    prep.dx     = {cfg.ox[31], cfg.ox} - {in_data[31], in_data[31:0]};
    prep.dz     = {cfg.oz[31], cfg.oz} - {in_data[95], in_data[95:64]};
    prep.ymin   = by48 <<< 14;
    prep.ymax   = (by48 + {24'd0, in_data[143:120]}) <<< 14;
    prep.radius = in_data[119:96];
    prep.last   = in_last;
  end

  assign in_ready = (count != CntW'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = qmem[rptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == PtrW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= prep;
    end
  end

endmodule

FILE: hdl/rcnp_back.sv
module rcnp_back #(
  parameter int MAX_OBJECTS = rcnp_pkg::MaxObjectsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rcnp_pkg::rcnp_cfg_t  cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  rcnp_pkg::rcnp_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [7:0]           out_index,
  output logic [31:0]          out_dist
);
  import rcnp_pkg::*;

  localparam int CntW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  rcnp_state_t state, state_next;
  rcnp_item_t  item;

  logic         mul_start, mul_done, mul_neg, issued, is_mul;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;

  logic [31:0]        a;
  logic [31:0]        a_sum;
  logic [25:0]        r;
  logic signed [50:0] h;
  logic signed [50:0] k;
  logic [51:0]        rr;
  logic [83:0]        arr;
  logic [83:0]        sx;
  logic [45:0]        srem;
  logic [45:0]        srem2;
  logic [45:0]        strial;
  logic [41:0]        s;
  logic [5:0]         cnt;
  logic               root_sel;
  logic signed [51:0] n;
  logic [63:0]        divq;
  logic [31:0]        drem;
  logic [32:0]        drem2;
  logic               q_big;
  logic signed [49:0] hy;
  logic signed [49:0] ymin50;
  logic signed [49:0] ymax50;
  logic               hit;

  logic [31:0]      nearest_distance;
  logic [CntW-1:0]  nearest_index;
  logic [CntW-1:0]  item_count;
  logic             any_hit;
  logic [CntW+7:0]  index_ext;

  rcnp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .neg   (mul_neg),
    .done  (mul_done),
    .prod  (prod)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = 64'd0;
    mul_b  = 64'd0;
    mul_neg = 1'b0;
    is_mul = 1'b1;
    case (state)
      B_AXX: begin
        mul_a = mag64({{48{cfg.dx[15]}}, cfg.dx});
        mul_b = mul_a;
      end
      B_AZZ: begin
        mul_a = mag64({{48{cfg.dz[15]}}, cfg.dz});
        mul_b = mul_a;
      end
      B_R: begin
        mul_a = {40'd0, item.radius};
        mul_b = {54'd0, cfg.scale};
      end
      B_H1: begin
        mul_a   = mag64({{31{item.dx[32]}}, item.dx});
        mul_b   = mag64({{48{cfg.dx[15]}}, cfg.dx});
        mul_neg = item.dx[32] ^ cfg.dx[15];
      end
      B_H2: begin
        mul_a   = mag64({{31{item.dz[32]}}, item.dz});
        mul_b   = mag64({{48{cfg.dz[15]}}, cfg.dz});
        mul_neg = item.dz[32] ^ cfg.dz[15];
      end
      B_K1: begin
        mul_a   = mag64({{31{item.dx[32]}}, item.dx});
        mul_b   = mag64({{48{cfg.dz[15]}}, cfg.dz});
        mul_neg = item.dx[32] ^ cfg.dz[15];
      end
      B_K2: begin
        mul_a   = mag64({{31{item.dz[32]}}, item.dz});
        mul_b   = mag64({{48{cfg.dx[15]}}, cfg.dx});
        mul_neg = item.dz[32] ^ cfg.dx[15];
      end
      B_RR: begin
        mul_a = {38'd0, r};
        mul_b = {38'd0, r};
      end
      B_ARR: begin
        mul_a = {32'd0, a};
        mul_b = {12'd0, rr};
      end
      B_KK: begin
        mul_a = mag64({{13{k[50]}}, k});
        mul_b = mul_a;
      end
      B_HY: begin
        mul_a   = mag64({{48{cfg.dy[15]}}, cfg.dy});
        mul_b   = {32'd0, divq[31:0]};
        mul_neg = cfg.dy[15];
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !issued;

  // Combinational helpers for the square root, division and hit test.
  always_comb begin
    a_sum  = a + prod[31:0];
    srem2  = {srem[43:0], sx[83:82]};
    strial = {2'b00, s, 2'b01};
    n      = root_sel ? (-{h[50], h} + {10'd0, s}) : (-{h[50], h} - {10'd0, s});
    drem2  = {drem, divq[63]};
    q_big  = (divq[63:32] != 32'd0) || (divq[31:0] == 32'hFFFF_FFFF);
    ymin50 = {{2{item.ymin[47]}}, item.ymin};
    ymax50 = {{2{item.ymax[47]}}, item.ymax};
    hit    = (hy >= ymin50) && (hy <= ymax50) && (divq[31:0] < nearest_distance);
    index_ext = {8'd0, nearest_index};
  end

  // Next state and the queue pop.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_AXX;
        end
      end
      B_AXX: if (mul_done) state_next = B_AZZ;
      B_AZZ: if (mul_done) state_next = (a_sum == 32'd0) ? B_FIN : B_R;
      B_R:   if (mul_done) state_next = B_H1;
      B_H1:  if (mul_done) state_next = B_H2;
      B_H2:  if (mul_done) state_next = B_K1;
      B_K1:  if (mul_done) state_next = B_K2;
      B_K2:  if (mul_done) state_next = B_RR;
      B_RR:  if (mul_done) state_next = B_ARR;
      B_ARR: if (mul_done) state_next = B_KK;
      B_KK: begin
        if (mul_done) begin
          state_next = (prod[99:0] > {16'd0, arr}) ? B_FIN : B_SQRT;
        end
      end
      B_SQRT: if (cnt == 6'd41) state_next = B_ROOT;
      B_ROOT: begin
        if (n < 0) begin
          state_next = root_sel ? B_FIN : B_ROOT;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV: if (cnt == 6'd63) state_next = B_RNG;
      B_RNG: begin
        if (q_big) begin
          state_next = root_sel ? B_FIN : B_ROOT;
        end else begin
          state_next = B_HY;
        end
      end
      B_HY:    if (mul_done) state_next = B_CHECK;
      B_CHECK: state_next = root_sel ? B_FIN : B_ROOT;
      B_FIN: begin
        if (!item.last || !out_valid) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: handshake of the multiplier, step counter, running best.
  always_ff @(posedge clk) begin
    if (rst) begin
      issued           <= 1'b0;
      cnt              <= '0;
      out_valid        <= 1'b0;
      any_hit          <= 1'b0;
      nearest_distance <= 32'hFFFF_FFFF;
      nearest_index    <= '0;
      item_count       <= '0;
    end else begin
      if (mul_done) begin
        issued <= 1'b0;
      end else if (mul_start) begin
        issued <= 1'b1;
      end
      if ((state == B_SQRT || state == B_DIV) && state_next == state) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == B_CHECK && hit) begin
        nearest_distance <= divq[31:0];
        nearest_index    <= item_count;
        any_hit          <= 1'b1;
      end
      if (state == B_FIN) begin
        if (item.last) begin
          if (!out_valid) begin
            out_valid        <= 1'b1;
            any_hit          <= 1'b0;
            nearest_distance <= 32'hFFFF_FFFF;
            nearest_index    <= '0;
            item_count       <= '0;
          end
        end else if (item_count != CntW'(MAX_OBJECTS - 1)) begin
          item_count <= item_count + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (mul_done) begin
      case (state)
        B_AXX: a   <= prod[31:0];
        B_AZZ: a   <= a_sum;
        B_R:   r   <= prod[33:8];
        B_H1:  h   <= prod[50:0];
        B_H2:  h   <= h + prod[50:0];
        B_K1:  k   <= prod[50:0];
        B_K2:  k   <= k - prod[50:0];
        B_RR:  rr  <= prod[51:0];
        B_ARR: arr <= prod[83:0];
        B_KK: begin
          sx       <= arr - prod[83:0];
          srem     <= '0;
          s        <= '0;
          root_sel <= 1'b0;
        end
        B_HY: hy <= {{4{cfg.oy[31]}}, cfg.oy, 14'd0} + prod[49:0];
        default: ;
      endcase
    end
    // Square root, two bits of the radicand and one result bit a step.
    if (state == B_SQRT) begin
      sx <= {sx[81:0], 2'b00};
      if (srem2 >= strial) begin
        srem <= srem2 - strial;
        s    <= {s[40:0], 1'b1};
      end else begin
        srem <= srem2;
        s    <= {s[40:0], 1'b0};
      end
    end
    if (state == B_ROOT) begin
      divq <= {n[49:0], 14'd0};
      drem <= '0;
      if (n < 0) begin
        root_sel <= 1'b1;
      end
    end
    // Restoring division, one quotient bit a step.
    if (state == B_DIV) begin
      if (drem2 >= {1'b0, a}) begin
        drem <= 32'(drem2 - {1'b0, a});
        divq <= {divq[62:0], 1'b1};
      end else begin
        drem <= drem2[31:0];
        divq <= {divq[62:0], 1'b0};
      end
    end
    if (state == B_RNG && q_big) begin
      root_sel <= 1'b1;
    end
    if (state == B_CHECK) begin
      root_sel <= 1'b1;
    end
    if (state == B_FIN && item.last && !out_valid) begin
      out_found <= any_hit;
      out_index <= any_hit ? index_ext[7:0] : 8'd0;
      out_dist  <= any_hit ? nearest_distance : 32'd0;
    end
  end

endmodule

FILE: hdl/ray_cylinder_nearest_pick.sv
// Nearest pick of vertical cylinders along a ray.
// Write the ray origin, direction and radius scale on the cfg port while the
// block is idle, then stream cylinders on the s_axis channel. Each transfer is
// one cylinder; s_tlast marks the last one of a pick. For that item one
// result transfer leaves on m_axis: found flag, stream index of the nearest
// hit and its ray distance. Other items give no result.
// A two-entry queue takes cylinders while the back part works on earlier
// ones. The back part runs one cylinder at a time through a shared
// shift-add multiplier (one multiplier bit a cycle), a 42-step square root
// and a 64-step division per root, so an item with no horizontal direction
// ends early and one with both roots in range takes longest; the time is
// set mostly by the multiplier widths and the two divisions.
// A result is valid the cycle after the back part finishes its last item.
// If m_tready is low the result waits in the output register and the back
// part holds before its next result; the queue keeps taking items until full.
// Reset clears the queue, the running best and the registers to their
// default ray (straight down, scale 1.0).
module ray_cylinder_nearest_pick #(
  parameter int MAX_OBJECTS = rcnp_pkg::MaxObjectsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_x, base_y, center_z, radius, span
  input  logic [143:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found, best_index, hit_distance, zero fill
  output logic [47:0]  m_tdata
);
  import rcnp_pkg::*;

  rcnp_cfg_t  cfg;
  rcnp_item_t q_item;
  logic       q_valid, q_pop;
  logic       found;
  logic [7:0] best_index;
  logic [31:0] hit_distance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ox    <= '0;
      cfg.oy    <= '0;
      cfg.oz    <= '0;
      cfg.dx    <= '0;
      cfg.dy    <= -16'sd16384;
      cfg.dz    <= '0;
      cfg.scale <= 10'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOriginX: cfg.ox    <= cfg_data;
        RegOriginY: cfg.oy    <= cfg_data;
        RegOriginZ: cfg.oz    <= cfg_data;
        RegDirX:    cfg.dx    <= cfg_data[15:0];
        RegDirY:    cfg.dy    <= cfg_data[15:0];
        RegDirZ:    cfg.dz    <= cfg_data[15:0];
        RegScale:   cfg.scale <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  rcnp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rcnp_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (found),
    .out_index (best_index),
    .out_dist  (hit_distance)
  );

  assign m_tdata = {7'd0, hit_distance, best_index, found};

endmodule

FILE: verif/ray_cylinder_nearest_pick_tb.sv
`timescale 1ns / 1ps

module ray_cylinder_nearest_pick_tb;
  import rcnp_pkg::*;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] by;
    logic signed [31:0] cz;
    logic [23:0]        rad;
    logic [23:0]        span;
    bit                 last;
  } cylinder_t;

  typedef struct {
    bit          found;
    logic [7:0]  idx;
    logic [31:0] distance;
  } pick_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;

  // Shadow of the ray registers.
  logic signed [31:0] ray_ox = 0, ray_oy = 0, ray_oz = 0;
  logic signed [15:0] ray_dx = 0, ray_dy = -16384, ray_dz = 0;
  logic [9:0]         ray_scale = 256;

  // Running best of the pick in progress.
  int unsigned  pick_count = 0;
  logic [31:0]  pick_dist = '1;
  logic [7:0]   pick_idx = '0;
  bit           pick_any = 0;

  cylinder_t    cylinder_q[$];
  pick_t        pick_q[$];
  cylinder_t    cur_cyl;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           n_errors = 0;
  int           n_accepted = 0;
  int           n_picks = 0;
  int           n_found = 0;

  ray_cylinder_nearest_pick dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Candidate root: keep it when it is in front, in range, inside the span and nearer.
  task automatic consider_root(longint n, longint a, longint ymin, longint ymax);
    logic [63:0] num;
    logic [63:0] q;
    longint      hy;
    if (n < 0) return;
    num = 64'(n) << 14;
    q = num / 64'(a);
    if (q >= 64'hFFFF_FFFF) return;
    hy = longint'(ray_oy) * 16384 + longint'(ray_dy) * longint'(q);
    if (hy >= ymin && hy <= ymax && q[31:0] < pick_dist) begin
      pick_dist = q[31:0];
      pick_idx = pick_count[7:0];
      pick_any = 1;
    end
  endtask

  // Intersect one cylinder with the ray and queue the pick result on the last one.
  task automatic track_cylinder(cylinder_t c);
    longint a, r, dx, dz, h, k, s, ymin, ymax;
    logic signed [127:0] disc, cand;
    pick_t p;
    a = longint'(ray_dx) * ray_dx + longint'(ray_dz) * ray_dz;
    if (a != 0) begin
      r = (longint'(c.rad) * longint'(ray_scale)) >>> 8;
      dx = longint'(ray_ox) - longint'(c.cx);
      dz = longint'(ray_oz) - longint'(c.cz);
      h = dx * ray_dx + dz * ray_dz;
      k = dx * ray_dz - dz * ray_dx;
      disc = 128'(a) * 128'(r) * 128'(r) - 128'(k) * 128'(k);
      if (disc >= 0) begin
        s = 0;
        for (int b = 43; b >= 0; b--) begin
          cand = 128'(s | (64'd1 << b));
          if (cand * cand <= disc) s = longint'(cand);
        end
        ymin = longint'(c.by) * 16384;
        ymax = (longint'(c.by) + longint'(c.span)) * 16384;
        consider_root(-h - s, a, ymin, ymax);
        consider_root(-h + s, a, ymin, ymax);
      end
    end
    if (c.last) begin
      p.found = pick_any;
      p.idx = pick_any ? pick_idx : 8'd0;
      p.distance = pick_any ? pick_dist : 32'd0;
      pick_q.push_back(p);
      pick_count = 0;
      pick_dist = '1;
      pick_idx = '0;
      pick_any = 0;
    end else if (pick_count < 255) begin
      pick_count++;
    end
  endtask

  // Cylinder driver: tracks each accepted transfer, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_cylinder(cur_cyl);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (cylinder_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cyl = cylinder_q.pop_front();
          s_tdata <= {cur_cyl.span, cur_cyl.rad, cur_cyl.cz, cur_cyl.by, cur_cyl.cx};
          s_tlast <= cur_cyl.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    pick_t p;
    if (!rst && m_tvalid && m_tready) begin
      if (pick_q.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        n_errors++;
      end else begin
        p = pick_q.pop_front();
        n_picks++;
        if (p.found) n_found++;
        if (m_tdata[0] !== p.found) begin
          $error("found: expected %0d, got %0d", p.found, m_tdata[0]);
          n_errors++;
        end
        if (m_tdata[8:1] !== p.idx) begin
          $error("best_index: expected %0d, got %0d", p.idx, m_tdata[8:1]);
          n_errors++;
        end
        if (m_tdata[40:9] !== p.distance) begin
          $error("hit_distance: expected %0d, got %0d", p.distance, m_tdata[40:9]);
          n_errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      RegOriginX: ray_ox = v;
      RegOriginY: ray_oy = v;
      RegOriginZ: ray_oz = v;
      RegDirX:    ray_dx = v[15:0];
      RegDirY:    ray_dy = v[15:0];
      RegDirZ:    ray_dz = v[15:0];
      RegScale:   ray_scale = v[9:0];
      default:    ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                         logic [9:0] sc);
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegOriginZ, oz);
    write_reg(RegDirX, {{16{dx[15]}}, dx});
    write_reg(RegDirY, {{16{dy[15]}}, dy});
    write_reg(RegDirZ, {{16{dz[15]}}, dz});
    write_reg(RegScale, {22'd0, sc});
  endtask

  // Wait until every cylinder is sent and every result has come, then let the
  // back part finish items that give no result.
  task automatic drain();
    while (cylinder_q.size() > 0 || s_tvalid || pick_q.size() > 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic add_cyl(logic [31:0] cx, logic [31:0] by, logic [31:0] cz,
                         logic [23:0] rad, logic [23:0] span, bit last);
    cylinder_t c;
    c.cx = cx; c.by = by; c.cz = cz; c.rad = rad; c.span = span; c.last = last;
    cylinder_q.push_back(c);
  endtask

  // Random ray: mostly near the world origin, sometimes anywhere.
  task automatic random_ray();
    logic [31:0] o[3];
    for (int i = 0; i < 3; i++)
      o[i] = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    set_ray(o[0], o[1], o[2],
            16'($signed($urandom_range(32768)) - 16384),
            16'($signed($urandom_range(32768)) - 16384),
            16'($signed($urandom_range(32768)) - 16384),
            ($urandom_range(4) == 0) ? 10'($urandom()) :
            (($urandom_range(1) != 0) ? 10'd256 : 10'd205));
  endtask

  // One pick query: most cylinders are placed on the ray, the rest are noise.
  task automatic random_query(int n);
    longint t, px, py, pz, rr;
    logic [23:0] rad;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        t = $urandom_range(1 << 17);
        px = longint'(ray_ox) + ((longint'(ray_dx) * t) >>> 14);
        py = longint'(ray_oy) + ((longint'(ray_dy) * t) >>> 14);
        pz = longint'(ray_oz) + ((longint'(ray_dz) * t) >>> 14);
        rad = 24'($urandom_range(1 << 12, 1));
        rr = rad;
        add_cyl(32'(px + $signed($urandom_range(2 * rr)) - rr),
                32'(py - $urandom_range(1 << 11)),
                32'(pz + $signed($urandom_range(2 * rr)) - rr),
                rad, 24'($urandom_range(1 << 12)), i == n - 1);
      end else begin
        add_cyl($urandom(), $urandom(), $urandom(), 24'($urandom()), 24'($urandom()),
                i == n - 1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset ray points straight down: no horizontal part, always a miss.
    add_cyl(0, -512, 0, 256, 1024, 0);
    add_cyl(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 1);
    drain();

    // Horizontal ray along +x at height zero.
    set_ray(0, 0, 0, 16'sd16384, 0, 0, 10'd256);
    add_cyl(32'd2560, -256, 0, 256, 512, 0);       // plain hit
    add_cyl(32'd2560, -256, 0, 256, 512, 0);       // same distance, earlier one stays
    add_cyl(-32'sd2560, -256, 0, 256, 512, 0);     // behind the origin
    add_cyl(32'd1280, -256, 32'd256, 256, 512, 0); // tangent, nearer
    add_cyl(32'd768, 32'd256, 0, 256, 512, 0);     // ray passes under it
    add_cyl(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1);
    add_cyl(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1);
    add_cyl(32'd2560, -256, 0, 256, 512, 1);
    drain();

    // Scale extremes, full-length directions negative in x and z, extreme origin.
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd16384, 16'sd16384,
            -16'sd16384, 10'd1023);
    add_cyl(32'h8000_0000, 32'h7FFF_F000, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0);
    add_cyl(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1);
    drain();
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'sd1, 16'sd0, 0, 10'd0);
    add_cyl(32'h7FFF_FFFF, 32'h8000_0000, 0, 24'hFF_FFFF, 24'hFF_FFFF, 1);
    drain();
    // Tiny direction so the far root does not fit.
    set_ray(0, 0, 0, 16'sd1, 0, 0, 10'd256);
    add_cyl(32'h4000_0000, -256, 0, 24'h00_8000, 512, 0);
    add_cyl(32'd2560, -256, 0, 256, 512, 1);
    drain();

    // Random part: one long query to saturate the index, then short ones.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      random_ray();
      if (ph == 0) begin
        random_query(270);
      end else begin
        for (int qn = 0; qn < 8; qn++) random_query($urandom_range(8, 1));
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    $display("%0d cylinders accepted, %0d picks checked (%0d with a hit), %0d mismatches",
             n_accepted, n_picks, n_found, n_errors);
    $display("covered reset ray, extremes, ties, tangents, behind/too far, index saturation");
    if (n_errors == 0 && pick_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: ray_cylinder_nearest_pick.f
hdl/rcnp_pkg.sv
hdl/rcnp_mul.sv
hdl/rcnp_front.sv
hdl/rcnp_back.sv
hdl/ray_cylinder_nearest_pick.sv
verif/ray_cylinder_nearest_pick_tb.sv
